// ===== hw/rtl/rv32ex_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32ex_pkg
// Shared types and constants of the rv32i subset execute block: sizes of the
// register file and data memory, instruction codes and the request structs
// that pass between the pipeline and its two storage arrays.
// ----------------------------------------------------------------------------
package rv32ex_pkg;

  // storage sizes
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegAw    = $clog2(NumRegs);
  localparam int unsigned XLen     = 32;
  localparam int unsigned MemWords = 4096;  // power of two, index wraps by mask
  localparam int unsigned MemAw    = $clog2(MemWords);
  localparam int unsigned MemIdxW  = 12;    // width of the reported index

  // major opcodes
  localparam logic [6:0] OpcOp    = 7'b0110011;
  localparam logic [6:0] OpcOpImm = 7'b0010011;
  localparam logic [6:0] OpcLoad  = 7'b0000011;
  localparam logic [6:0] OpcStore = 7'b0100011;

  // funct3 codes of the alu subset
  localparam logic [2:0] F3Add = 3'b000;
  localparam logic [2:0] F3Xor = 3'b100;
  localparam logic [2:0] F3Or  = 3'b110;
  localparam logic [2:0] F3And = 3'b111;

  // funct7 codes
  localparam logic [6:0] F7Base = 7'b0000000;
  localparam logic [6:0] F7Alt  = 7'b0100000;

  // result status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFunct  = 2'd1;
  localparam logic [1:0] StOpcode = 2'd2;

  // register file read request
  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr_a;
    logic [RegAw-1:0] addr_b;
  } rf_rd_t;

  // register file write request
  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [XLen-1:0]  data;
  } rf_wr_t;

  // data memory request
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [MemAw-1:0] addr;
    logic [XLen-1:0]  wdata;
  } dmem_req_t;

endpackage

// ===== hw/rtl/rv32ex_regfile.sv =====
// ----------------------------------------------------------------------------
// rv32ex_regfile
// Integer register file: two registered read ports, one write port, with
// write-through on a same-cycle write and a valid bit per entry so that
// reset clears the whole file at once. x0 is never written and reads zero.
// ----------------------------------------------------------------------------
module rv32ex_regfile
  import rv32ex_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rf_rd_t          rd_i,
  input  rf_wr_t          wr_i,
  output logic [XLen-1:0] rdata_a_o,
  output logic [XLen-1:0] rdata_b_o
);

  logic [XLen-1:0]    mem_q [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [XLen-1:0]    rdata_a_q;
  logic [XLen-1:0]    rdata_b_q;

  // per-entry valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // storage array and registered reads with write-through
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      if (wr_i.en && (wr_i.addr == rd_i.addr_a)) begin
        rdata_a_q <= wr_i.data;
      end else if (valid_q[rd_i.addr_a]) begin
        rdata_a_q <= mem_q[rd_i.addr_a];
      end else begin
        rdata_a_q <= '0;
      end
      if (wr_i.en && (wr_i.addr == rd_i.addr_b)) begin
        rdata_b_q <= wr_i.data;
      end else if (valid_q[rd_i.addr_b]) begin
        rdata_b_q <= mem_q[rd_i.addr_b];
      end else begin
        rdata_b_q <= '0;
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

  // x0 stays zero
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> (wr_i.addr != '0))
    else $error("register file write to x0");

  // x0 never becomes valid
  a_x0_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0])
    else $error("x0 marked valid");

endmodule

// ===== hw/rtl/rv32ex_dmem.sv =====
// ----------------------------------------------------------------------------
// rv32ex_dmem
// Word-indexed data memory with one read/write port and registered read
// data. After reset a clearing pass writes zero to every word, one word a
// cycle, and busy_o stays high until it is done.
// ----------------------------------------------------------------------------
module rv32ex_dmem
  import rv32ex_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dmem_req_t       req_i,
  output logic [XLen-1:0] rdata_o,
  output logic            busy_o
);

  logic [XLen-1:0]  mem_q [MemWords];
  logic [XLen-1:0]  rdata_q;
  logic [MemAw-1:0] clr_q;
  logic [MemAw-1:0] clr_d;
  logic             busy_q;
  logic             busy_d;

  // clearing sweep counter
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (clr_q == MemAw'(MemWords - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // storage array, clearing writes take the port while busy
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

  // no access competes with the clearing sweep
  a_no_access_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.wr_en || req_i.rd_en) |-> !busy_q)
    else $error("data memory access during clearing pass");

  // a request is either a read or a write
  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.wr_en && req_i.rd_en))
    else $error("data memory read and write in one cycle");

endmodule

// ===== hw/rtl/rv32i_subset_execute.sv =====
// ----------------------------------------------------------------------------
// rv32i_subset_execute
// Pipeline: an instruction passes the execute stage register and then the
// result stage register before out_valid_o rises for it.
// Throughput: one instruction per cycle while out_ready_i is high and no clearing pass runs,
// set by the single data memory port and the register file read at transfer plus forwarding
// from the result stage. Reset: the register file clears at once; the data memory runs a
// clearing pass over all 4096 words, during which in_ready_o is low.
// Executes an rv32i subset (add/sub/xor/or/and, immediates, load, store).
// ----------------------------------------------------------------------------
module rv32i_subset_execute
  import rv32ex_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instr_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               wrote_reg_o,
  output logic [RegAw-1:0]   dest_reg_o,
  output logic [XLen-1:0]    reg_value_o,
  output logic               wrote_mem_o,
  output logic [MemIdxW-1:0] mem_index_o,
  output logic [1:0]         status_o
);

  // execute stage
  logic        s1_valid_q;
  logic [31:0] s1_instr_q;

  // result stage
  logic               s2_valid_q;
  logic               s2_wreg_q;
  logic               s2_ld_q;
  logic [RegAw-1:0]   s2_dest_q;
  logic [XLen-1:0]    s2_val_q;
  logic               s2_wmem_q;
  logic [MemIdxW-1:0] s2_idx_q;
  logic [1:0]         s2_status_q;

  logic      in_xfer;
  logic      out_xfer;
  logic      s1_adv;
  logic      dmem_busy;
  rf_rd_t    rf_rd;
  rf_wr_t    rf_wr;
  dmem_req_t dmem_req;
  logic [XLen-1:0] rf_rdata_a;
  logic [XLen-1:0] rf_rdata_b;
  logic [XLen-1:0] dmem_rdata;

  // decoded fields and execute results
  logic [6:0]       opc;
  logic [RegAw-1:0] rd;
  logic [2:0]       f3;
  logic [RegAw-1:0] rs1;
  logic [RegAw-1:0] rs2;
  logic [6:0]       f7;
  logic [XLen-1:0]  imm_i;
  logic [XLen-1:0]  imm_s;
  logic [XLen-1:0]  op_a;
  logic [XLen-1:0]  op_b;
  logic [XLen-1:0]  opnd;
  logic [XLen-1:0]  addr_sum;
  logic [XLen-1:0]  ex_val;
  logic             ex_wreg;
  logic             ex_ld;
  logic             ex_wmem;
  logic             ex_mem;
  logic [1:0]       ex_status;

  // handshake
  assign out_xfer   = s2_valid_q && out_ready_i;
  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !dmem_busy && (!s1_valid_q || s1_adv);
  assign in_xfer    = in_valid_i && in_ready_o;

  // register file, read at transfer, written when a result transfers
  assign rf_rd.en     = in_xfer;
  assign rf_rd.addr_a = instr_word_i[19:15];
  assign rf_rd.addr_b = instr_word_i[24:20];
  assign rf_wr.en     = out_xfer && s2_wreg_q;
  assign rf_wr.addr   = s2_dest_q;
  assign rf_wr.data   = reg_value_o;

  rv32ex_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rf_rd),
    .wr_i      (rf_wr),
    .rdata_a_o (rf_rdata_a),
    .rdata_b_o (rf_rdata_b)
  );

  // field decode
  assign opc   = s1_instr_q[6:0];
  assign rd    = s1_instr_q[11:7];
  assign f3    = s1_instr_q[14:12];
  assign rs1   = s1_instr_q[19:15];
  assign rs2   = s1_instr_q[24:20];
  assign f7    = s1_instr_q[31:25];
  assign imm_i = {{20{s1_instr_q[31]}}, s1_instr_q[31:20]};
  assign imm_s = {{20{s1_instr_q[31]}}, s1_instr_q[31:25], s1_instr_q[11:7]};

  // operand forwarding from the result stage, which is not yet written back
  always_comb begin
    op_a = rf_rdata_a;
    op_b = rf_rdata_b;
    if (s2_valid_q && s2_wreg_q && (s2_dest_q == rs1)) begin
      op_a = reg_value_o;
    end
    if (s2_valid_q && s2_wreg_q && (s2_dest_q == rs2)) begin
      op_b = reg_value_o;
    end
  end

  // execute
  always_comb begin
    ex_status = StOk;
    ex_val    = '0;
    ex_wreg   = 1'b0;
    ex_ld     = 1'b0;
    ex_wmem   = 1'b0;
    ex_mem    = 1'b0;
    opnd      = (opc == OpcOp) ? op_b : imm_i;
    addr_sum  = op_a + ((opc == OpcStore) ? imm_s : imm_i);
    case (opc)
      OpcOp, OpcOpImm: begin
        if ((opc == OpcOp) && !((f7 == F7Base) || ((f7 == F7Alt) && (f3 == F3Add)))) begin
          ex_status = StFunct;
        end else begin
          case (f3)
            F3Add: begin
              ex_val  = ((opc == OpcOp) && (f7 == F7Alt)) ? (op_a - opnd) : (op_a + opnd);
              ex_wreg = 1'b1;
            end
            F3Xor: begin
              ex_val  = op_a ^ opnd;
              ex_wreg = 1'b1;
            end
            F3Or: begin
              ex_val  = op_a | opnd;
              ex_wreg = 1'b1;
            end
            F3And: begin
              ex_val  = op_a & opnd;
              ex_wreg = 1'b1;
            end
            default: begin
              ex_status = StFunct;
            end
          endcase
        end
      end
      OpcLoad: begin
        ex_mem  = 1'b1;
        ex_ld   = 1'b1;
        ex_wreg = 1'b1;
      end
      OpcStore: begin
        ex_mem  = 1'b1;
        ex_wmem = 1'b1;
      end
      default: begin
        ex_status = StOpcode;
      end
    endcase
    // destination x0 drops the write
    if (rd == '0) begin
      ex_wreg = 1'b0;
      ex_val  = '0;
    end
  end

  // data memory access as the instruction leaves execute
  assign dmem_req.rd_en = s1_adv && ex_ld;
  assign dmem_req.wr_en = s1_adv && ex_wmem;
  assign dmem_req.addr  = addr_sum[MemAw-1:0];
  assign dmem_req.wdata = op_b;

  rv32ex_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dmem_req),
    .rdata_o (dmem_rdata),
    .busy_o  (dmem_busy)
  );

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (out_xfer) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_instr_q <= instr_word_i;
    end
    if (s1_adv) begin
      s2_wreg_q   <= ex_wreg;
      s2_ld_q     <= ex_ld && ex_wreg;
      s2_dest_q   <= ex_wreg ? rd : '0;
      s2_val_q    <= ex_val;
      s2_wmem_q   <= ex_wmem;
      s2_idx_q    <= ex_mem ? MemIdxW'(addr_sum[MemAw-1:0]) : '0;
      s2_status_q <= ex_status;
    end
  end

  // result ports, load data comes straight from the memory read register
  assign out_valid_o = s2_valid_q;
  assign wrote_reg_o = s2_wreg_q;
  assign dest_reg_o  = s2_dest_q;
  assign reg_value_o = s2_ld_q ? dmem_rdata : s2_val_q;
  assign wrote_mem_o = s2_wmem_q;
  assign mem_index_o = s2_idx_q;
  assign status_o    = s2_status_q;

  // a blocked execute stage keeps its instruction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && !out_ready_i) |=> (s1_valid_q && $stable(s1_instr_q)))
    else $error("execute stage lost its instruction under stall");

  // a register write result never names x0 and carries ok status
  a_wreg_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_wreg_q) |-> ((s2_dest_q != '0) && (s2_status_q == StOk)))
    else $error("bad register write result");

endmodule
